// ===== hw/rtl/xtbs_pkg.sv =====
package xtbs_pkg;

  // Scanner states
  typedef enum logic [2:0] {
    ST_TEXT    = 3'd0,
    ST_LT      = 3'd1,
    ST_END     = 3'd2,
    ST_PI      = 3'd3,
    ST_START   = 3'd4,
    ST_QUOTE   = 3'd5,
    ST_EMPTY   = 3'd6,
    ST_SELF    = 3'd7
  } scan_state_t;

  // Output record kinds
  typedef enum logic [1:0] {
    KIND_ELEMENT = 2'd0,
    KIND_END     = 2'd1,
    KIND_NUL     = 2'd2
  } record_kind_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam logic [15:0] LEN_MAX       = 16'hFFFF;
  localparam logic [15:0] BATCH_DEFAULT = 16'd1024;

  // Per-byte events from the scanner
  typedef struct packed {
    logic set_pending;  // byte after '<' of a start tag
    logic push;         // '>' closing a start tag
    logic pop;          // '>' closing an end tag
    logic self_close;   // '>' closing a self-closing tag
  } scan_evt_t;

  // One stack entry; the parent is captured at push time
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] loc;
    logic [15:0] len;
    logic [31:0] parent;
    logic        has_parent;
  } stack_entry_t;

  localparam int ENTRY_W = $bits(stack_entry_t);

endpackage

// ===== hw/rtl/xml_tag_boundary_scanner_unit.sv =====
// Channel | Dir | Ports                               | Contents
// in_     | in  | in_tvalid/in_tready/in_tdata/in_tlast | one XML byte; tlast = end of stream
// out_    | out | out_tvalid/out_tready/out_tdata/     | element or summary record;
//         |     | out_tuser/out_tlast                  | tuser = kind, tlast = batch closed
// cfg_    | in  | cfg_wr_en/cfg_wr_data                | batch_size register
//
// One byte per cycle while the output register drains; a record lands there the next cycle.
// A tag-closing byte right after a push or pop would stall on the stack RAM read,
// but every path between two stack operations takes at least three bytes, so it never does.
// Reset (rst_n low, synchronous) clears the scanner, counters and flags; the stack
// RAM is not cleared, only entries below the stack count are ever used.
// A full output register with out_tready low holds the input side.
module xml_tag_boundary_scanner_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // config
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,    // batch_size
  // byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,       // char_byte[7:0]
  input  logic         in_tlast,       // end_of_stream
  // records
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,      // tag_location[31:0], tag_length[47:32],
                                       // tag_id[79:48], parent_id[111:80],
                                       // has_parent[112], leftover_count[128:113],
                                       // stack_overflow_seen[129],
                                       // stack_underflow_seen[130], zero[135:131]
  output logic [1:0]   out_tuser,      // record_kind[1:0]
  output logic         out_tlast       // closes_batch
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int EW = xtbs_pkg::ENTRY_W;

  // Registers
  logic [15:0]   batch_r;
  logic [31:0]   offset_r, offset_nxt;
  logic [31:0]   pending_r, pending_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic [15:0]   fill_r, fill_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          unf_r, unf_nxt;
  logic          stopped_r, stopped_nxt;
  logic          stale_r, stale_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [135:0]  out_data_r;
  logic [1:0]    out_kind_r;
  logic          out_last_r;

  // Handshake and step qualifiers
  xtbs_pkg::scan_evt_t evt;
  logic          out_free;
  logic          needs_top;
  logic          in_acc;
  logic          is_nul;
  logic          step;
  logic          fin;
  logic          has_top;
  logic          full;
  logic          push_ok, push_drop, pop_ok, pop_under, self_emit, emit_elem, load;

  // Stack RAM
  logic [CW-1:0] count_m1;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  xtbs_pkg::stack_entry_t top_q;
  xtbs_pkg::stack_entry_t push_entry;

  // Record datapath
  logic [31:0]   len_raw;
  logic [15:0]   tag_len;
  logic [15:0]   limit;
  logic [16:0]   fill_inc;
  logic          closes;
  logic [31:0]   rec_loc, rec_id, rec_parent;
  logic [15:0]   rec_len;
  logic          rec_hp;
  logic [135:0]  rec_data;
  logic [1:0]    rec_kind;
  logic          rec_last;

  xtbs_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .char_byte (in_tdata),
    .evt       (evt)
  );

  // Accept while the output register can take a record; interlock only a
  // tag-closing byte on a top-of-stack read still in flight.
  assign out_free  = !out_valid_r || out_tready;
  assign needs_top = evt.push || evt.pop || evt.self_close;
  assign in_tready = out_free && !(stale_r && needs_top);
  assign in_acc    = in_tvalid && in_tready;

  assign is_nul = (in_tdata == xtbs_pkg::CH_NUL);
  assign step   = in_acc && !stopped_r && !in_tlast && !is_nul;
  assign fin    = in_acc && !stopped_r && (in_tlast || is_nul);

  assign has_top   = (count_r != '0);
  assign full      = (count_r >= CW'(STACK_DEPTH));
  assign push_ok   = step && evt.push && !full;
  assign push_drop = step && evt.push && full;
  assign pop_ok    = step && evt.pop && has_top;
  assign pop_under = step && evt.pop && !has_top;
  assign self_emit = step && evt.self_close;
  assign emit_elem = pop_ok || self_emit;
  assign load      = emit_elem || fin;

  // Read the top entry every cycle; stale_r marks it not yet settled after a push or pop.
  assign count_m1 = count_r - CW'(1);
  assign rd_addr  = count_m1[AW-1:0];
  assign top_q    = xtbs_pkg::stack_entry_t'(rd_data);

  // Tag length from '<' through '>', saturating
  assign len_raw = offset_r + 32'd1 - pending_r;
  assign tag_len = (len_raw > {16'd0, xtbs_pkg::LEN_MAX}) ? xtbs_pkg::LEN_MAX : len_raw[15:0];

  always_comb begin
    push_entry.id         = next_id_r;
    push_entry.loc        = pending_r;
    push_entry.len        = tag_len;
    push_entry.parent     = has_top ? top_q.id : 32'd0;
    push_entry.has_parent = has_top;
  end

  xtbs_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (EW'(push_entry)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Batch accounting: a zero batch size acts as one
  assign limit    = (batch_r == 16'd0) ? 16'd1 : batch_r;
  assign fill_inc = {1'b0, fill_r} + 17'd1;
  assign closes   = (fill_inc >= {1'b0, limit});

  // Assemble the record
  always_comb begin
    if (pop_ok) begin
      rec_loc    = top_q.loc;
      rec_len    = top_q.len;
      rec_id     = top_q.id;
      rec_parent = top_q.parent;
      rec_hp     = top_q.has_parent;
    end else begin
      rec_loc    = pending_r;
      rec_len    = tag_len;
      rec_id     = next_id_r;
      rec_parent = has_top ? top_q.id : 32'd0;
      rec_hp     = has_top;
    end
    if (emit_elem) begin
      rec_kind = xtbs_pkg::KIND_ELEMENT;
      rec_last = closes;
      rec_data = {5'd0, unf_r, ovf_r, 16'd0, rec_hp, rec_parent, rec_id, rec_len, rec_loc};
    end else begin
      rec_kind = is_nul && !in_tlast ? xtbs_pkg::KIND_NUL : xtbs_pkg::KIND_END;
      rec_last = 1'b0;
      rec_data = {5'd0, unf_r, ovf_r, fill_r, 1'b0, 32'd0, 32'd0, 16'd0, 32'd0};
    end
  end

  // Next-state of the bookkeeping registers
  always_comb begin
    offset_nxt    = step ? offset_r + 32'd1 : offset_r;
    pending_nxt   = (step && evt.set_pending) ? offset_r - 32'd1 : pending_r;
    next_id_nxt   = (step && (evt.push || evt.self_close)) ? next_id_r + 32'd1 : next_id_r;
    fill_nxt      = emit_elem ? (closes ? 16'd0 : fill_inc[15:0]) : fill_r;
    count_nxt     = push_ok ? count_r + CW'(1) : (pop_ok ? count_m1 : count_r);
    ovf_nxt       = ovf_r || push_drop;
    unf_nxt       = unf_r || pop_under;
    stopped_nxt   = stopped_r || fin;
    stale_nxt     = push_ok || pop_ok;
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r     <= xtbs_pkg::BATCH_DEFAULT;
      offset_r    <= '0;
      pending_r   <= '0;
      next_id_r   <= '0;
      fill_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      unf_r       <= 1'b0;
      stopped_r   <= 1'b0;
      stale_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        batch_r <= cfg_wr_data;
      end
      offset_r    <= offset_nxt;
      pending_r   <= pending_nxt;
      next_id_r   <= next_id_nxt;
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      unf_r       <= unf_nxt;
      stopped_r   <= stopped_nxt;
      stale_r     <= stale_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold until loaded
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= rec_data;
      out_kind_r <= rec_kind;
      out_last_r <= rec_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // Stack never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // No stack operation reads a top entry still in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && stale_r |-> !needs_top)
    else $error("stack access during pending top read");

  // A summary record always leaves the block stopped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != xtbs_pkg::KIND_ELEMENT) |-> stopped_r)
    else $error("summary emitted without stop");

  // Only element records close a batch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_kind_r == xtbs_pkg::KIND_ELEMENT)
    else $error("batch mark on summary record");

  // A push moves the count up by exactly one
  assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not advance stack count");

endmodule

// ===== hw/rtl/xtbs_ram.sv =====
module xtbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/xtbs_scan.sv =====
module xtbs_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  logic [7:0]         char_byte,
  output xtbs_pkg::scan_evt_t evt
);

  xtbs_pkg::scan_state_t state_r;
  xtbs_pkg::scan_state_t state_nxt;

  logic is_gt;
  logic is_quote;

  assign is_gt    = (char_byte == xtbs_pkg::CH_GT);
  assign is_quote = (char_byte == xtbs_pkg::CH_DQUOTE) || (char_byte == xtbs_pkg::CH_SQUOTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xtbs_pkg::ST_TEXT;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      xtbs_pkg::ST_TEXT: begin
        if (char_byte == xtbs_pkg::CH_LT) state_nxt = xtbs_pkg::ST_LT;
      end
      xtbs_pkg::ST_LT: begin
        if (char_byte == xtbs_pkg::CH_SLASH) begin
          state_nxt = xtbs_pkg::ST_END;
        end else if (char_byte == xtbs_pkg::CH_QMARK || char_byte == xtbs_pkg::CH_BANG) begin
          state_nxt = xtbs_pkg::ST_PI;
        end else begin
          state_nxt = xtbs_pkg::ST_START;
        end
      end
      xtbs_pkg::ST_END: begin
        if (is_gt) state_nxt = xtbs_pkg::ST_TEXT;
      end
      xtbs_pkg::ST_PI: begin
        if (is_gt) begin
          state_nxt = xtbs_pkg::ST_TEXT;
        end else if (char_byte == xtbs_pkg::CH_SLASH) begin
          state_nxt = xtbs_pkg::ST_EMPTY;
        end
      end
      xtbs_pkg::ST_START: begin
        if (is_quote) begin
          state_nxt = xtbs_pkg::ST_QUOTE;
        end else if (char_byte == xtbs_pkg::CH_SLASH) begin
          state_nxt = xtbs_pkg::ST_SELF;
        end else if (is_gt) begin
          state_nxt = xtbs_pkg::ST_TEXT;
        end
      end
      xtbs_pkg::ST_QUOTE: begin
        if (is_quote) state_nxt = xtbs_pkg::ST_START;
      end
      xtbs_pkg::ST_EMPTY: begin
        if (is_gt) state_nxt = xtbs_pkg::ST_TEXT;
      end
      xtbs_pkg::ST_SELF: begin
        state_nxt = is_gt ? xtbs_pkg::ST_TEXT : xtbs_pkg::ST_START;
      end
      default: state_nxt = xtbs_pkg::ST_TEXT;
    endcase
  end

  // Events for the current byte
  always_comb begin
    evt = '0;
    case (state_r)
      xtbs_pkg::ST_LT: begin
        evt.set_pending = (char_byte != xtbs_pkg::CH_SLASH) &&
                          (char_byte != xtbs_pkg::CH_QMARK) &&
                          (char_byte != xtbs_pkg::CH_BANG);
      end
      xtbs_pkg::ST_END:   evt.pop        = is_gt;
      xtbs_pkg::ST_START: evt.push       = is_gt;
      xtbs_pkg::ST_SELF:  evt.self_close = is_gt;
      default:            evt            = '0;
    endcase
  end

endmodule
